/* sv/ntt_pkg.sv */
// package: types, constants and helpers for the neighbour trust table
`timescale 1ns / 1ps
`default_nettype none
package ntt_pkg;

  localparam int TableDepth = 16;
  localparam int MaxRes     = 16;
  localparam int IdxW       = (TableDepth > 1) ? $clog2(TableDepth) : 1;
  localparam int CntW       = $clog2(TableDepth + 1);

  typedef enum logic [1:0] {
    OP_UPDATE = 2'd0,
    OP_TICK   = 2'd1,
    OP_REMOVE = 2'd2,
    OP_LIST   = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    STS_UPDATED    = 3'd0,
    STS_CREATED    = 3'd1,
    STS_ZERO_ID    = 3'd2,
    STS_FULL       = 3'd3,
    STS_TICK_DONE  = 3'd4,
    STS_REMOVED    = 3'd5,
    STS_LIST_ENTRY = 3'd6,
    STS_LIST_EMPTY = 3'd7
  } status_e;

  typedef enum logic [2:0] {
    REG_ACTIVATE   = 3'd0,
    REG_DEACTIVATE = 3'd1,
    REG_CEILING    = 3'd2,
    REG_BONUS      = 3'd3,
    REG_DECAY      = 3'd4
  } reg_idx_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_UPD_SCAN,
    ST_UPD_APPLY,
    ST_TICK_VISIT,
    ST_WD_SCAN,
    ST_TICK_FREE,
    ST_RM_SCAN,
    ST_LIST_CNT,
    ST_LIST_EMIT,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic [1:0] op;
    logic [7:0] id;
    logic [7:0] hops;
    logic [7:0] via;
    logic [7:0] from_id;
  } in_t;

  typedef struct packed {
    logic [2:0] status;
    logic [3:0] slot;
    logic [7:0] out_id;
    logic [7:0] out_trust;
    logic       out_active;
    logic [7:0] out_hops;
    logic [7:0] out_via;
    logic [4:0] count;
    logic       last;
  } out_t;

  typedef struct packed {
    logic [7:0] activate_level;
    logic [7:0] deactivate_level;
    logic [7:0] trust_ceiling;
    logic [7:0] direct_bonus;
    logic [7:0] decay_step;
  } cfg_t;

  typedef struct packed {
    logic [7:0] id;
    logic [7:0] trust;
    logic       active;
    logic [7:0] hops;
    logic [7:0] via;
  } entry_t;

  // build one result, the entry fields only when the status reports an entry
  function automatic out_t mk_rsp(status_e sts, logic [3:0] slot, entry_t e,
                                  logic [4:0] cnt, logic last);
    out_t r;
    r = '0;
    r.status = sts;
    if (sts == STS_UPDATED || sts == STS_CREATED || sts == STS_LIST_ENTRY) begin
      r.slot       = slot;
      r.out_id     = e.id;
      r.out_trust  = e.trust;
      r.out_active = e.active;
      r.out_hops   = e.hops;
      r.out_via    = e.via;
    end
    r.count = cnt;
    r.last  = last;
    return r;
  endfunction

endpackage
`default_nettype wire

/* sv/ntt_cfg.sv */
// configuration registers of the neighbour trust table
`timescale 1ns / 1ps
`default_nettype none
module ntt_cfg (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          cfg_we_i,
  input  wire logic [2:0]    cfg_idx_i,
  input  wire logic [7:0]    cfg_data_i,
  output ntt_pkg::cfg_t      cfg_o
);

  ntt_pkg::cfg_t cfg_q, cfg_d;

  // register write decode, unknown indexes ignored
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        ntt_pkg::REG_ACTIVATE:   cfg_d.activate_level   = cfg_data_i;
        ntt_pkg::REG_DEACTIVATE: cfg_d.deactivate_level = cfg_data_i;
        ntt_pkg::REG_CEILING:    cfg_d.trust_ceiling    = cfg_data_i;
        ntt_pkg::REG_BONUS:      cfg_d.direct_bonus     = cfg_data_i;
        ntt_pkg::REG_DECAY:      cfg_d.decay_step       = cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.activate_level   <= 8'd7;
      cfg_q.deactivate_level <= 8'd7;
      cfg_q.trust_ceiling    <= 8'd10;
      cfg_q.direct_bonus     <= 8'd2;
      cfg_q.decay_step       <= 8'd1;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule
`default_nettype wire

/* sv/ntt_table.sv */
// neighbour entry storage: one read port, one write port
`timescale 1ns / 1ps
`default_nettype none
module ntt_table (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic [ntt_pkg::IdxW-1:0]  rd_idx_i,
  output ntt_pkg::entry_t                rd_entry_o,
  input  wire logic                      wr_en_i,
  input  wire logic [ntt_pkg::IdxW-1:0]  wr_idx_i,
  input  wire ntt_pkg::entry_t           wr_entry_i
);

  ntt_pkg::entry_t ent_q [ntt_pkg::TableDepth];

  // all slots free after reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < ntt_pkg::TableDepth; i++) ent_q[i] <= '0;
    end else if (wr_en_i) begin
      ent_q[wr_idx_i] <= wr_entry_i;
    end
  end

  assign rd_entry_o = ent_q[rd_idx_i];

endmodule
`default_nettype wire

/* sv/neighbor_trust_table_core.sv */
// neighbour trust table: sequencer walking the table one slot per cycle in its
// scans, holding while a result waits; update: scan all slots, then apply;
// remove: scan all slots; list: count routable entries, then report them;
// tick: decay each slot with trust, withdraw routes per deactivation, free
// unreachable slots; one request at a time, limited by the single table read port
// reset clears every slot, the entry count and sets the register defaults
`timescale 1ns / 1ps
`default_nettype none
module neighbor_trust_table_core (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_ready_o,
  input  wire ntt_pkg::in_t in_req_i,
  output logic            out_valid_o,
  input  wire logic       out_ready_i,
  output ntt_pkg::out_t   out_rsp_o,
  input  wire logic       cfg_we_i,
  input  wire logic [2:0] cfg_idx_i,
  input  wire logic [7:0] cfg_data_i
);

  localparam int IdxW = ntt_pkg::IdxW;
  localparam int CntW = ntt_pkg::CntW;
  localparam logic [IdxW-1:0] LastIdx = IdxW'(ntt_pkg::TableDepth - 1);

  ntt_pkg::cfg_t   cfg;
  ntt_pkg::entry_t rd_e, wr_e;
  logic [IdxW-1:0] rd_idx, wr_idx;
  logic            wr_en;

  ntt_pkg::state_e  state_q, state_d;
  ntt_pkg::in_t     req_q, req_d;
  ntt_pkg::status_e sts_q, sts_d;
  ntt_pkg::out_t    out_q, out_d;
  logic             ov_q, ov_d;
  logic [IdxW-1:0]  idx_q, idx_d, oidx_q, oidx_d, fslot_q, fslot_d, frees_q, frees_d;
  logic             found_q, found_d, freev_q, freev_d;
  logic [7:0]       relay_q, relay_d;
  logic [CntW-1:0]  cnt_q, cnt_d, tot_q, tot_d, k_q, k_d;

  ntt_cfg u_cfg (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i, .cfg_o(cfg)
  );

  ntt_table u_table (
    .clk_i, .rst_ni,
    .rd_idx_i(rd_idx), .rd_entry_o(rd_e),
    .wr_en_i(wr_en), .wr_idx_i(wr_idx), .wr_entry_i(wr_e)
  );

  // shared decode of the slot under the read port
  logic            out_free, last_idx, occ, routable, skip, deact;
  logic            found_n, freev_n, hit_cnt;
  logic [IdxW-1:0] fslot_n, frees_n;
  logic [7:0]      t_dec, t_add;
  logic [8:0]      sum;
  logic [CntW-1:0] tot_n;

  always_comb begin
    out_free = !ov_q || out_ready_i;
    last_idx = (idx_q == LastIdx);
    case (state_q)
      ntt_pkg::ST_UPD_APPLY:  rd_idx = found_q ? fslot_q : frees_q;
      ntt_pkg::ST_TICK_VISIT,
      ntt_pkg::ST_TICK_FREE:  rd_idx = oidx_q;
      default:                rd_idx = idx_q;
    endcase
    occ      = (rd_e.id != 8'd0);
    routable = occ && (rd_e.active || rd_e.via != 8'd0);
    // decay, saturating at zero
    t_dec = (rd_e.trust > cfg.decay_step) ? rd_e.trust - cfg.decay_step : 8'd0;
    skip  = !occ || rd_e.trust == 8'd0;
    deact = rd_e.active && (t_dec < cfg.deactivate_level);
    // direct sighting: saturating add, then clamp to the ceiling
    sum   = {1'b0, rd_e.trust} + {1'b0, cfg.direct_bonus};
    t_add = sum[8] ? 8'hFF : sum[7:0];
    if (t_add > cfg.trust_ceiling) t_add = cfg.trust_ceiling;
    // lookup scan bookkeeping
    found_n = found_q;
    fslot_n = fslot_q;
    freev_n = freev_q;
    frees_n = frees_q;
    if (rd_e.id == req_q.id && !found_q) begin
      found_n = 1'b1;
      fslot_n = idx_q;
    end
    if (!occ && !freev_q) begin
      freev_n = 1'b1;
      frees_n = idx_q;
    end
    // routable count, capped at the result limit
    hit_cnt = routable && (tot_q < CntW'(ntt_pkg::MaxRes));
    tot_n   = tot_q + CntW'(hit_cnt);
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ntt_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          case (in_req_i.op)
            ntt_pkg::OP_UPDATE:
              state_d = (in_req_i.id == 8'd0) ? ntt_pkg::ST_DONE : ntt_pkg::ST_UPD_SCAN;
            ntt_pkg::OP_TICK:   state_d = ntt_pkg::ST_TICK_VISIT;
            ntt_pkg::OP_REMOVE: state_d = ntt_pkg::ST_RM_SCAN;
            default:            state_d = ntt_pkg::ST_LIST_CNT;
          endcase
        end
      end
      ntt_pkg::ST_UPD_SCAN:  if (last_idx) state_d = ntt_pkg::ST_UPD_APPLY;
      ntt_pkg::ST_UPD_APPLY: if (out_free) state_d = ntt_pkg::ST_IDLE;
      ntt_pkg::ST_TICK_VISIT: begin
        if (skip) begin
          if (oidx_q == LastIdx) state_d = ntt_pkg::ST_DONE;
        end else if (deact) begin
          state_d = ntt_pkg::ST_WD_SCAN;
        end else begin
          state_d = ntt_pkg::ST_TICK_FREE;
        end
      end
      ntt_pkg::ST_WD_SCAN: if (last_idx) state_d = ntt_pkg::ST_TICK_FREE;
      ntt_pkg::ST_TICK_FREE:
        state_d = (oidx_q == LastIdx) ? ntt_pkg::ST_DONE : ntt_pkg::ST_TICK_VISIT;
      ntt_pkg::ST_RM_SCAN: if (last_idx) state_d = ntt_pkg::ST_DONE;
      ntt_pkg::ST_LIST_CNT: begin
        if (last_idx) state_d = (tot_n == '0) ? ntt_pkg::ST_DONE : ntt_pkg::ST_LIST_EMIT;
      end
      ntt_pkg::ST_LIST_EMIT: begin
        if (out_free) begin
          if (routable && k_q < tot_q && (k_q + CntW'(1)) == tot_q) state_d = ntt_pkg::ST_IDLE;
          else if (last_idx) state_d = ntt_pkg::ST_IDLE;
        end
      end
      ntt_pkg::ST_DONE: if (out_free) state_d = ntt_pkg::ST_IDLE;
      default: state_d = ntt_pkg::ST_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    req_d   = req_q;
    sts_d   = sts_q;
    idx_d   = idx_q;
    oidx_d  = oidx_q;
    fslot_d = fslot_q;
    frees_d = frees_q;
    found_d = found_q;
    freev_d = freev_q;
    relay_d = relay_q;
    cnt_d   = cnt_q;
    tot_d   = tot_q;
    k_d     = k_q;
    out_d   = out_q;
    ov_d    = ov_q && !out_ready_i;
    wr_en   = 1'b0;
    wr_idx  = rd_idx;
    wr_e    = rd_e;
    in_ready_o = (state_q == ntt_pkg::ST_IDLE);
    case (state_q)
      ntt_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          req_d   = in_req_i;
          idx_d   = '0;
          oidx_d  = '0;
          found_d = 1'b0;
          freev_d = 1'b0;
          tot_d   = '0;
          k_d     = '0;
          case (in_req_i.op)
            ntt_pkg::OP_UPDATE: sts_d = ntt_pkg::STS_ZERO_ID;
            ntt_pkg::OP_TICK:   sts_d = ntt_pkg::STS_TICK_DONE;
            ntt_pkg::OP_REMOVE: sts_d = ntt_pkg::STS_REMOVED;
            default:            sts_d = ntt_pkg::STS_LIST_EMPTY;
          endcase
        end
      end
      // find the entry and the lowest free slot
      ntt_pkg::ST_UPD_SCAN: begin
        found_d = found_n;
        fslot_d = fslot_n;
        freev_d = freev_n;
        frees_d = frees_n;
        idx_d   = idx_q + IdxW'(1);
      end
      ntt_pkg::ST_UPD_APPLY: begin
        if (out_free) begin
          if (found_q) begin
            if (req_q.hops == 8'd0) begin
              wr_e.trust = t_add;
              if (t_add > cfg.activate_level) wr_e.active = 1'b1;
            end else if (req_q.hops < rd_e.hops || rd_e.hops == 8'd0) begin
              wr_e.via  = req_q.via;
              wr_e.hops = req_q.hops;
            end
            wr_en = 1'b1;
            out_d = ntt_pkg::mk_rsp(ntt_pkg::STS_UPDATED, 4'(rd_idx), wr_e, 5'(cnt_q), 1'b1);
          end else if (freev_q) begin
            wr_e.id     = req_q.id;
            wr_e.via    = req_q.via;
            wr_e.hops   = req_q.hops;
            wr_e.active = 1'b0;
            wr_e.trust  = (req_q.hops == 8'd0) ? cfg.direct_bonus : 8'd0;
            wr_en = 1'b1;
            cnt_d = cnt_q + CntW'(1);
            out_d = ntt_pkg::mk_rsp(ntt_pkg::STS_CREATED, 4'(rd_idx), wr_e, 5'(cnt_d), 1'b1);
          end else begin
            out_d = ntt_pkg::mk_rsp(ntt_pkg::STS_FULL, '0, '0, 5'(cnt_q), 1'b1);
          end
          ov_d = 1'b1;
        end
      end
      // decay one occupied slot with trust, skipping empty or zero-trust slots
      ntt_pkg::ST_TICK_VISIT: begin
        if (skip) begin
          oidx_d = oidx_q + IdxW'(1);
        end else begin
          wr_e.trust = t_dec;
          if (deact) wr_e.active = 1'b0;
          wr_en   = 1'b1;
          relay_d = rd_e.id;
          idx_d   = '0;
        end
      end
      // withdraw routes through a deactivated relay, freeing entries with no trust left
      ntt_pkg::ST_WD_SCAN: begin
        if (occ && rd_e.via == relay_q) begin
          wr_en = 1'b1;
          if (rd_e.trust != 8'd0) begin
            wr_e.hops = 8'd0;
            wr_e.via  = 8'd0;
          end else begin
            wr_e.id = 8'd0;
            if (cnt_q != '0) cnt_d = cnt_q - CntW'(1);
          end
        end
        idx_d = idx_q + IdxW'(1);
      end
      // free the visited slot once unreachable
      ntt_pkg::ST_TICK_FREE: begin
        if (occ && rd_e.trust == 8'd0 && rd_e.via == 8'd0) begin
          wr_en   = 1'b1;
          wr_e.id = 8'd0;
          if (cnt_q != '0) cnt_d = cnt_q - CntW'(1);
        end
        oidx_d = oidx_q + IdxW'(1);
      end
      ntt_pkg::ST_RM_SCAN: begin
        if (occ && rd_e.id == req_q.id && rd_e.via == req_q.from_id) begin
          wr_en = 1'b1;
          if (rd_e.trust != 8'd0) begin
            wr_e.hops = 8'd0;
            wr_e.via  = 8'd0;
          end else begin
            wr_e.id = 8'd0;
            if (cnt_q != '0) cnt_d = cnt_q - CntW'(1);
          end
        end
        idx_d = idx_q + IdxW'(1);
      end
      // count routable entries, then report them
      ntt_pkg::ST_LIST_CNT: begin
        tot_d = tot_n;
        idx_d = idx_q + IdxW'(1);
      end
      ntt_pkg::ST_LIST_EMIT: begin
        if (out_free) begin
          if (routable && k_q < tot_q) begin
            out_d = ntt_pkg::mk_rsp(ntt_pkg::STS_LIST_ENTRY, 4'(idx_q), rd_e, 5'(cnt_q),
                                    (k_q + CntW'(1)) == tot_q);
            ov_d  = 1'b1;
            k_d   = k_q + CntW'(1);
          end
          idx_d = idx_q + IdxW'(1);
        end
      end
      ntt_pkg::ST_DONE: begin
        if (out_free) begin
          out_d = ntt_pkg::mk_rsp(sts_q, '0, '0, 5'(cnt_q), 1'b1);
          ov_d  = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ntt_pkg::ST_IDLE;
      ov_q    <= 1'b0;
      cnt_q   <= '0;
      idx_q   <= '0;
      oidx_q  <= '0;
      found_q <= 1'b0;
      freev_q <= 1'b0;
      tot_q   <= '0;
      k_q     <= '0;
      sts_q   <= ntt_pkg::STS_UPDATED;
    end else begin
      state_q <= state_d;
      ov_q    <= ov_d;
      cnt_q   <= cnt_d;
      idx_q   <= idx_d;
      oidx_q  <= oidx_d;
      found_q <= found_d;
      freev_q <= freev_d;
      tot_q   <= tot_d;
      k_q     <= k_d;
      sts_q   <= sts_d;
    end
  end

  // request payload and result register
  always_ff @(posedge clk_i) begin
    req_q   <= req_d;
    out_q   <= out_d;
    fslot_q <= fslot_d;
    frees_q <= frees_d;
    relay_q <= relay_d;
  end

  assign out_valid_o = ov_q;
  assign out_rsp_o   = out_q;

endmodule
`default_nettype wire
